FILE: design/sql_keyword_tokenizer_unit_defines.svh
// Assertion macros for the checker file of the tokenizer.
`ifndef SQL_KEYWORD_TOKENIZER_UNIT_DEFINES_SVH
`define SQL_KEYWORD_TOKENIZER_UNIT_DEFINES_SVH

// Implication in the same cycle, switched off while reset is high.
`define SQLKT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqlkt check failed");

// Implication into the next cycle, switched off while reset is high.
`define SQLKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqlkt check failed");

// Implication into the next cycle that also holds across reset.
`define SQLKT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sqlkt check failed");

`endif

FILE: design/sqlkt_pkg.sv
package sqlkt_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_POSITION_BITS = 16;
  localparam int DEF_COUNT_BITS    = 16;
  localparam int DEF_QUEUE_DEPTH   = 4;

  // Output fields of 16 bits saturate at this value.
  localparam int          FIELD_BITS = 16;
  localparam logic [15:0] FIELD_MAX  = 16'hFFFF;

  // Token kinds.
  localparam logic [3:0] KIND_IDENT   = 4'd0;
  localparam logic [3:0] KIND_CREATE  = 4'd1;
  localparam logic [3:0] KIND_TABLE   = 4'd2;
  localparam logic [3:0] KIND_INT     = 4'd3;
  localparam logic [3:0] KIND_TEXT    = 4'd4;
  localparam logic [3:0] KIND_LPAREN  = 4'd5;
  localparam logic [3:0] KIND_RPAREN  = 4'd6;
  localparam logic [3:0] KIND_COMMA   = 4'd7;
  localparam logic [3:0] KIND_UNKNOWN = 4'd8;
  localparam logic [3:0] KIND_EOF     = 4'd9;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  // Keyword table, in the order CREATE, TABLE, INT, TEXT.
  localparam int NUM_KW     = 4;
  localparam int KW_MAX_LEN = 6;
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd5, 3'd3, 3'd4};
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{8'h43, 8'h52, 8'h45, 8'h41, 8'h54, 8'h45, 8'h00, 8'h00},
    '{8'h54, 8'h41, 8'h42, 8'h4C, 8'h45, 8'h00, 8'h00, 8'h00},
    '{8'h49, 8'h4E, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h54, 8'h45, 8'h58, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // One token as it leaves the block; kind sits in the lowest bits.
  typedef struct packed {
    logic [15:0] index;
    logic [7:0]  chr;
    logic [15:0] length;
    logic [15:0] start;
    logic [3:0]  kind;
  } token_t;

  // Tokens caused by one byte; the first is always valid.
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } rec_t;

  localparam int OUT_TDATA_BITS = 64;

  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    is_word = is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDERSCORE);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // Mask of keywords whose character at position idx equals b.
  function automatic logic [NUM_KW-1:0] kw_match(input logic [2:0] idx,
                                                 input logic [7:0] b);
    logic [NUM_KW-1:0] m;
    m = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (idx < KW_LEN[k] && KW_TEXT[k][idx] == b) begin
        m[k] = 1'b1;
      end
    end
    kw_match = m;
  endfunction

endpackage

FILE: design/sql_keyword_tokenizer_unit.sv
// Channel  Direction  Fields (lowest bit up)
// s_*      in         tdata: text_byte[7:0]
// m_*      out        tdata: token_kind[3:0], token_start[19:4], token_length[35:20],
//                     single_char[43:36], token_index[59:44], zeros[63:60];
//                     tlast: run_last
//
// One byte is taken every cycle while the token queue has room; results leave at one
// token a cycle through the output register while m_tready is high, so a byte that closes
// a word and makes a token of its own sends two tokens out.
// A token is written to the queue at the edge that takes its byte and is then loaded into
// the output register, which drives m_tdata.
// Reset is synchronous and clears the lexer state, the queue and the output valid; no
// clearing pass follows.
// A stalled output fills the queue, and s_tready falls only once it is full.
module sql_keyword_tokenizer_unit #(
  parameter int POSITION_BITS = sqlkt_pkg::DEF_POSITION_BITS,
  parameter int COUNT_BITS    = sqlkt_pkg::DEF_COUNT_BITS,
  parameter int QUEUE_DEPTH   = sqlkt_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,  // text_byte
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [sqlkt_pkg::OUT_TDATA_BITS-1:0]  m_tdata,  // kind, start, length, char, index
  output logic                                  m_tlast
);

  logic             accept;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  sqlkt_pkg::rec_t  rec;
  sqlkt_pkg::rec_t  head;

  // A byte is taken whenever the queue can hold what it may make.
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  sqlkt_front #(
    .POSITION_BITS (POSITION_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (s_tdata),
    .push      (push),
    .rec       (rec)
  );

  sqlkt_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .rec_in (rec),
    .full   (full),
    .pop    (pop),
    .head   (head),
    .empty  (empty)
  );

  sqlkt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: design/sqlkt_front.sv
module sqlkt_front #(
  parameter int POSITION_BITS = sqlkt_pkg::DEF_POSITION_BITS,
  parameter int COUNT_BITS    = sqlkt_pkg::DEF_COUNT_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       text_byte,
  output logic             push,
  output sqlkt_pkg::rec_t  rec
);

  localparam int PW = (POSITION_BITS > sqlkt_pkg::FIELD_BITS) ? POSITION_BITS
                                                              : sqlkt_pkg::FIELD_BITS;
  localparam int CW = (COUNT_BITS > sqlkt_pkg::FIELD_BITS) ? COUNT_BITS
                                                           : sqlkt_pkg::FIELD_BITS;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [COUNT_BITS-1:0]    CNT_MAX = '1;

  function automatic logic [15:0] clamp_pos(input logic [POSITION_BITS-1:0] v);
    logic [PW-1:0] ext;
    ext = PW'(v);
    clamp_pos = (ext > PW'(sqlkt_pkg::FIELD_MAX)) ? sqlkt_pkg::FIELD_MAX : ext[15:0];
  endfunction

  function automatic logic [15:0] clamp_cnt(input logic [COUNT_BITS-1:0] v);
    logic [CW-1:0] ext;
    ext = CW'(v);
    clamp_cnt = (ext > CW'(sqlkt_pkg::FIELD_MAX)) ? sqlkt_pkg::FIELD_MAX : ext[15:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [COUNT_BITS-1:0] v);
    sat_cnt = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Lexer state.
  logic                          in_word;
  logic [POSITION_BITS-1:0]      word_start;
  logic [POSITION_BITS-1:0]      word_length;
  logic [sqlkt_pkg::NUM_KW-1:0]  keyword_alive;
  logic [POSITION_BITS-1:0]      byte_position;
  logic [COUNT_BITS-1:0]         token_counter;

  logic                          in_word_next;
  logic [POSITION_BITS-1:0]      word_start_next;
  logic [POSITION_BITS-1:0]      word_length_next;
  logic [sqlkt_pkg::NUM_KW-1:0]  keyword_alive_next;
  logic [POSITION_BITS-1:0]      byte_position_next;
  logic [COUNT_BITS-1:0]         token_counter_next;

  logic                   b_alpha;
  logic                   b_word;
  logic                   b_space;
  logic                   b_end;
  logic                   word_goes_on;
  logic                   word_ends;
  logic                   single_valid;
  logic [2:0]             kw_idx;
  logic [3:0]             word_kind;
  logic [3:0]             single_kind;
  logic [COUNT_BITS-1:0]  cnt_after_word;
  sqlkt_pkg::token_t      word_tok;
  sqlkt_pkg::token_t      single_tok;

  // Classify the byte and build the tokens that it closes or makes.
  always_comb begin
    b_alpha      = sqlkt_pkg::is_alpha(text_byte);
    b_word       = sqlkt_pkg::is_word(text_byte);
    b_space      = sqlkt_pkg::is_space(text_byte);
    b_end        = (text_byte == sqlkt_pkg::CH_NUL);
    word_goes_on = in_word && b_word;
    word_ends    = in_word && !b_word;
    single_valid = !word_goes_on && (b_end || (!b_space && !b_alpha));

    // Positions past the longest keyword match nothing.
    kw_idx = (word_length > POSITION_BITS'(sqlkt_pkg::KW_MAX_LEN)) ? 3'd7
                                                                   : word_length[2:0];

    // The first keyword that is still alive and complete names the word.
    word_kind = sqlkt_pkg::KIND_IDENT;
    for (int k = sqlkt_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (keyword_alive[k] && word_length == POSITION_BITS'(sqlkt_pkg::KW_LEN[k])) begin
        word_kind = sqlkt_pkg::KIND_CREATE + 4'(k);
      end
    end

    unique case (text_byte)
      sqlkt_pkg::CH_NUL:    single_kind = sqlkt_pkg::KIND_EOF;
      sqlkt_pkg::CH_LPAREN: single_kind = sqlkt_pkg::KIND_LPAREN;
      sqlkt_pkg::CH_RPAREN: single_kind = sqlkt_pkg::KIND_RPAREN;
      sqlkt_pkg::CH_COMMA:  single_kind = sqlkt_pkg::KIND_COMMA;
      default:              single_kind = sqlkt_pkg::KIND_UNKNOWN;
    endcase

    cnt_after_word = word_ends ? sat_cnt(token_counter) : token_counter;

    word_tok.kind   = word_kind;
    word_tok.start  = clamp_pos(word_start);
    word_tok.length = clamp_pos(word_length);
    word_tok.chr    = sqlkt_pkg::CH_NUL;
    word_tok.index  = clamp_cnt(token_counter);

    single_tok.kind   = single_kind;
    single_tok.start  = clamp_pos(byte_position);
    single_tok.length = b_end ? 16'd0 : 16'd1;
    single_tok.chr    = text_byte;
    single_tok.index  = clamp_cnt(cnt_after_word);

    // The word token, when there is one, always goes first.
    if (word_ends) begin
      rec.first  = word_tok;
      rec.second = single_tok;
      rec.two    = single_valid;
    end else begin
      rec.first  = single_tok;
      rec.second = single_tok;
      rec.two    = 1'b0;
    end
    push = accept && (word_ends || single_valid);
  end

  // Next lexer state.
  always_comb begin
    byte_position_next = (byte_position == POS_MAX) ? byte_position
                                                    : byte_position + 1'b1;
    token_counter_next = single_valid ? sat_cnt(cnt_after_word) : cnt_after_word;
    word_start_next    = word_start;
    if (word_goes_on) begin
      in_word_next       = 1'b1;
      keyword_alive_next = keyword_alive & sqlkt_pkg::kw_match(kw_idx, text_byte);
      word_length_next   = (word_length == POS_MAX) ? word_length : word_length + 1'b1;
    end else if (b_alpha) begin
      in_word_next       = 1'b1;
      word_start_next    = byte_position;
      word_length_next   = POSITION_BITS'(1);
      keyword_alive_next = sqlkt_pkg::kw_match(3'd0, text_byte);
    end else begin
      in_word_next       = 1'b0;
      word_length_next   = '0;
      keyword_alive_next = '0;
    end
    // The end of text returns everything to the reset state.
    if (b_end) begin
      in_word_next       = 1'b0;
      word_start_next    = '0;
      word_length_next   = '0;
      keyword_alive_next = '0;
      byte_position_next = '0;
      token_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word       <= 1'b0;
      word_start    <= '0;
      word_length   <= '0;
      keyword_alive <= '0;
      byte_position <= '0;
      token_counter <= '0;
    end else if (accept) begin
      in_word       <= in_word_next;
      word_start    <= word_start_next;
      word_length   <= word_length_next;
      keyword_alive <= keyword_alive_next;
      byte_position <= byte_position_next;
      token_counter <= token_counter_next;
    end
  end

endmodule

FILE: design/sqlkt_queue.sv
module sqlkt_queue #(
  parameter int QUEUE_DEPTH = sqlkt_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sqlkt_pkg::rec_t  rec_in,
  output logic             full,
  input  logic             pop,
  output sqlkt_pkg::rec_t  head,
  output logic             empty
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);

  sqlkt_pkg::rec_t        slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr;
  logic [PTR_BITS-1:0]    rd_ptr;
  logic [CNT_BITS-1:0]    count;

  assign full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= rec_in;
    end
  end

endmodule

FILE: design/sqlkt_back.sv
module sqlkt_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sqlkt_pkg::rec_t                       head,
  input  logic                                  empty,
  output logic                                  pop,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [sqlkt_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  output logic                                  m_tlast
);

  localparam int PAD_BITS = sqlkt_pkg::OUT_TDATA_BITS - $bits(sqlkt_pkg::token_t);

  logic               phase;
  logic               load;
  logic               take;
  logic               last;
  sqlkt_pkg::token_t  cur;
  sqlkt_pkg::token_t  out_tok;

  // Pick the token of the head record that goes out next.
  always_comb begin
    load = !m_tvalid || m_tready;
    take = load && !empty;
    cur  = phase ? head.second : head.first;
    last = phase || !head.two;
    pop  = take && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else if (load) begin
      m_tvalid <= !empty;
      if (take) begin
        phase <= !last;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (take) begin
      out_tok <= cur;
      m_tlast <= last;
    end
  end

  assign m_tdata = {PAD_BITS'(0), out_tok};

endmodule

FILE: design/sqlkt_checker.sv
`include "sql_keyword_tokenizer_unit_defines.svh"

module sqlkt_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tready,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [sqlkt_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  input logic                                  m_tlast
);

  logic eof_out;

  // An end token is on offer.
  assign eof_out = m_tvalid && (m_tdata[3:0] == sqlkt_pkg::KIND_EOF);

  // A request that is held back stays offered.
  `SQLKT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // The output register is empty right after reset.
  `SQLKT_ASSERT_NEXT_ALWAYS(a_out_reset, clk, rst, !m_tvalid)

  // The empty queue takes bytes right after reset.
  `SQLKT_ASSERT_NEXT_ALWAYS(a_in_ready_reset, clk, rst, s_tready)

  // Only defined token kinds leave the block.
  `SQLKT_ASSERT_IMPL(a_kind_range, clk, rst, m_tvalid, m_tdata[3:0] <= sqlkt_pkg::KIND_EOF)

  // An end token has no length and is always the last result of its byte.
  `SQLKT_ASSERT_IMPL(a_eof_shape, clk, rst, eof_out, m_tlast && m_tdata[35:20] == 16'd0)

endmodule

bind sql_keyword_tokenizer_unit sqlkt_checker u_checker (.*);
